### design/pcmu_pkg.sv
// ----------------------------------------------------------------------------
// pcmu_pkg: shared types and helpers for the priority-ceiling mutex unit
// Request and status codes, bitmap sizing, bitmap helper functions.
// ----------------------------------------------------------------------------
package pcmu_pkg;

  // One bitmap entry per priority level; 0 is the highest priority.
  localparam int NUM_PRIOS = 64;
  localparam int PRIO_W    = 6;

  typedef logic [NUM_PRIOS-1:0] prio_map_t;
  typedef logic [PRIO_W-1:0]    prio_t;

  typedef enum logic [1:0] {
    REQ_LOCK      = 2'd0,
    REQ_UNLOCK    = 2'd1,
    REQ_TIMEOUT   = 2'd2,
    REQ_SET_READY = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OK_CEILING  = 3'd1,
    ST_WAITING     = 3'd2,
    ST_TIMED_OUT   = 3'd3,
    ST_NOT_OWNER   = 3'd4,
    ST_REFUSED_IRQ = 3'd5
  } status_t;

  // Single-bit mask for a priority; empty for a priority past the map.
  function automatic prio_map_t prio_mask(input prio_t idx);
    prio_map_t m;
    m = '0;
    if (32'(idx) < NUM_PRIOS) begin
      m[idx] = 1'b1;
    end
    return m;
  endfunction

  // Lowest-numbered set entry (highest priority); 0 when the map is empty.
  function automatic prio_t lowest_idx(input prio_map_t map);
    prio_t idx;
    idx = '0;
    for (int i = NUM_PRIOS - 1; i >= 0; i--) begin
      if (map[i]) begin
        idx = PRIO_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### design/priority_ceiling_mutex_unit_core.sv
// ----------------------------------------------------------------------------
// priority_ceiling_mutex_unit_core: one hardware mutex with ceiling raise
// Ready/waiter bitmaps, owner tracking, hand-off and top-ready reporting.
// ----------------------------------------------------------------------------
// Pipeline: a request beat goes into the input register, is processed by the
//   work stage and its result beat enters the result register.
// Throughput: one request beat per cycle unless out_stall holds the result; the
//   bitmap update and both priority encodes fit in the single work stage.
// Reset (rst, synchronous): both bitmaps empty, mutex free, owner 0 and not
//   raised, ceiling 0, both pipeline registers empty.
module priority_ceiling_mutex_unit_core (
  input  logic       clk,
  input  logic       rst,
  // ceiling register write port
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [5:0] task_prio,
  input  logic       in_interrupt,
  input  logic       ready_value,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic       grant_valid,
  output logic [5:0] granted_prio,
  output logic       any_ready,
  output logic [5:0] top_ready_prio
);

  // --------------------------------------------------------------------------
  // Mutex state
  // --------------------------------------------------------------------------
  pcmu_pkg::prio_map_t ready_set;
  pcmu_pkg::prio_map_t waiter_set;
  logic                mutex_free;
  pcmu_pkg::prio_t     owner_base_prio;
  logic                owner_raised;
  pcmu_pkg::prio_t     ceiling_prio;

  // --------------------------------------------------------------------------
  // Input register: holds one request beat until the work stage takes it
  // --------------------------------------------------------------------------
  logic                in_full;
  pcmu_pkg::req_t      in_req;
  pcmu_pkg::prio_t     in_prio;
  logic                in_irq;
  logic                in_rv;

  logic                out_load;  // result register can take a new result
  logic                work_fire; // buffered request is processed this cycle
  logic                in_take;   // a request beat is accepted this cycle

  assign out_load  = !out_valid || !out_stall;
  assign work_fire = in_full && out_load;
  assign in_stall  = in_full && !out_load;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (work_fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req  <= pcmu_pkg::req_t'(req_type);
      in_prio <= task_prio;
      in_irq  <= in_interrupt;
      in_rv   <= ready_value;
    end
  end

  // --------------------------------------------------------------------------
  // Work stage: next state and result for the buffered request
  // --------------------------------------------------------------------------
  pcmu_pkg::prio_map_t ready_set_next;
  pcmu_pkg::prio_map_t waiter_set_next;
  logic                mutex_free_next;
  pcmu_pkg::prio_t     owner_base_prio_next;
  logic                owner_raised_next;
  pcmu_pkg::status_t   status_next;
  logic                grant_next;
  pcmu_pkg::prio_t     first_waiter;
  pcmu_pkg::prio_map_t caller_mask;
  pcmu_pkg::prio_map_t owner_mask;
  pcmu_pkg::prio_map_t ceiling_mask;

  assign first_waiter = pcmu_pkg::lowest_idx(waiter_set);
  assign caller_mask  = pcmu_pkg::prio_mask(in_prio);
  assign owner_mask   = pcmu_pkg::prio_mask(owner_base_prio);
  assign ceiling_mask = pcmu_pkg::prio_mask(ceiling_prio);

  always_comb begin
    ready_set_next       = ready_set;
    waiter_set_next      = waiter_set;
    mutex_free_next      = mutex_free;
    owner_base_prio_next = owner_base_prio;
    owner_raised_next    = owner_raised;
    status_next          = pcmu_pkg::ST_OK;
    grant_next           = 1'b0;

    unique case (in_req)
      pcmu_pkg::REQ_LOCK: begin
        if (in_irq) begin
          status_next = pcmu_pkg::ST_REFUSED_IRQ;
        end else if (mutex_free) begin
          // free mutex: immediate grant
          mutex_free_next      = 1'b0;
          owner_base_prio_next = in_prio;
          owner_raised_next    = 1'b0;
          grant_next           = 1'b1;
          status_next          = (in_prio <= ceiling_prio) ? pcmu_pkg::ST_OK_CEILING
                                                           : pcmu_pkg::ST_OK;
        end else begin
          // held: a higher-priority caller raises an unraised owner that is below the
          // ceiling; the owner's ready bit moves to the ceiling entry if it was ready
          if (!owner_raised && owner_base_prio > ceiling_prio &&
              owner_base_prio > in_prio) begin
            if ((ready_set & owner_mask) != '0) begin
              ready_set_next = (ready_set_next & ~owner_mask) | ceiling_mask;
            end
            owner_raised_next = 1'b1;
          end
          waiter_set_next = waiter_set_next | caller_mask;
          ready_set_next  = ready_set_next & ~caller_mask;
          status_next     = pcmu_pkg::ST_WAITING;
        end
      end
      pcmu_pkg::REQ_UNLOCK: begin
        if (mutex_free || in_prio != owner_base_prio) begin
          status_next = pcmu_pkg::ST_NOT_OWNER;
        end else begin
          // restore the owner's base entry
          if (owner_raised || owner_base_prio == ceiling_prio) begin
            ready_set_next = ready_set_next &
                             ~(owner_raised ? ceiling_mask : owner_mask);
            ready_set_next = ready_set_next | owner_mask;
          end
          owner_raised_next = 1'b0;
          if (waiter_set != '0) begin
            // hand off to the highest-priority waiter
            waiter_set_next      = waiter_set_next & ~pcmu_pkg::prio_mask(first_waiter);
            ready_set_next       = ready_set_next | pcmu_pkg::prio_mask(first_waiter);
            owner_base_prio_next = first_waiter;
            grant_next           = 1'b1;
            status_next          = (first_waiter <= ceiling_prio) ? pcmu_pkg::ST_OK_CEILING
                                                                  : pcmu_pkg::ST_OK;
          end else begin
            mutex_free_next = 1'b1;
            status_next     = pcmu_pkg::ST_OK;
          end
        end
      end
      pcmu_pkg::REQ_TIMEOUT: begin
        waiter_set_next = waiter_set_next & ~caller_mask;
        status_next     = pcmu_pkg::ST_TIMED_OUT;
      end
      pcmu_pkg::REQ_SET_READY: begin
        ready_set_next = in_rv ? (ready_set_next | caller_mask)
                               : (ready_set_next & ~caller_mask);
        status_next    = pcmu_pkg::ST_OK;
      end
      default: begin
        status_next = pcmu_pkg::ST_OK;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State registers; the ceiling only takes writes while the mutex is free
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_set       <= '0;
      waiter_set      <= '0;
      mutex_free      <= 1'b1;
      owner_base_prio <= '0;
      owner_raised    <= 1'b0;
      ceiling_prio    <= '0;
    end else begin
      if (work_fire) begin
        ready_set       <= ready_set_next;
        waiter_set      <= waiter_set_next;
        mutex_free      <= mutex_free_next;
        owner_base_prio <= owner_base_prio_next;
        owner_raised    <= owner_raised_next;
      end
      if (cfg_wr_en && mutex_free) begin
        ceiling_prio <= cfg_wr_data;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register: reports the state after the step
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= work_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (work_fire) begin
      status         <= status_next;
      grant_valid    <= grant_next;
      granted_prio   <= mutex_free_next ? '0 : owner_base_prio_next;
      any_ready      <= (ready_set_next != '0);
      top_ready_prio <= pcmu_pkg::lowest_idx(ready_set_next);
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_free_not_raised: assert property (@(posedge clk) disable iff (rst)
    mutex_free |-> !owner_raised)
    else $error("free mutex marked as raised");

  a_raised_above_ceiling: assert property (@(posedge clk) disable iff (rst)
    owner_raised |-> owner_base_prio > ceiling_prio)
    else $error("raised owner not below ceiling");

  a_grant_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && grant_valid |->
      (status == pcmu_pkg::ST_OK || status == pcmu_pkg::ST_OK_CEILING))
    else $error("grant reported with failure status");

  a_empty_ready_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && !any_ready |-> top_ready_prio == '0)
    else $error("top ready nonzero with empty ready map");

  a_fire_to_result: assert property (@(posedge clk) disable iff (rst)
    work_fire |=> out_valid)
    else $error("processed request produced no result beat");

endmodule
